// File: sv/btpl_pkg.sv
// ----------------------------------------------------------------------------
// btpl_pkg
// Shared constants and types for the binary trie prefix lookup core.
// ----------------------------------------------------------------------------
package btpl_pkg;

    localparam int NODE_COUNT_DEF = 1024;
    localparam int ID_BITS_DEF    = 16;
    localparam int ADDR_BITS      = 32;
    localparam int LEN_W          = 6;
    localparam int OUT_ID_W       = 16;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_ALLOC = 3'b100
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_zero;
        logic wr_one;
        logic wr_mark;
    } t_mem_ctl;

endpackage

// File: sv/btpl_node_mem.sv
// ----------------------------------------------------------------------------
// btpl_node_mem
// Node pool storage: root node in flops, all other nodes in a memory with a
// single write port and one registered read port.
// ----------------------------------------------------------------------------
module btpl_node_mem #(
    parameter int NODE_COUNT = btpl_pkg::NODE_COUNT_DEF,
    parameter int ID_BITS    = btpl_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btpl_pkg::t_mem_ctl            i_ctl,
    input  logic [$clog2(NODE_COUNT)-1:0] i_rd_addr,
    input  logic [$clog2(NODE_COUNT)-1:0] i_wr_addr,
    input  logic [$clog2(NODE_COUNT)-1:0] i_wr_zero,
    input  logic [$clog2(NODE_COUNT)-1:0] i_wr_one,
    input  logic                          i_wr_has,
    input  logic [ID_BITS-1:0]            i_wr_id,
    output logic [$clog2(NODE_COUNT)-1:0] o_q_zero,
    output logic [$clog2(NODE_COUNT)-1:0] o_q_one,
    output logic                          o_q_has,
    output logic [ID_BITS-1:0]            o_q_id
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    logic [IDX_W-1:0]   mem_zero [NODE_COUNT];
    logic [IDX_W-1:0]   mem_one  [NODE_COUNT];
    logic               mem_has  [NODE_COUNT];
    logic [ID_BITS-1:0] mem_id   [NODE_COUNT];

    logic [IDX_W-1:0]   r_root_zero;
    logic [IDX_W-1:0]   r_root_one;
    logic               r_root_has;
    logic [ID_BITS-1:0] r_root_id;
    logic               r_rd_root;

    logic [IDX_W-1:0]   r_q_zero;
    logic [IDX_W-1:0]   r_q_one;
    logic               r_q_has;
    logic [ID_BITS-1:0] r_q_id;

    logic wr_root;
    assign wr_root = (i_wr_addr == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_zero <= '0;
            r_root_one  <= '0;
            r_root_has  <= 1'b0;
            r_rd_root   <= 1'b1;
        end else begin
            if (i_ctl.wr_zero && wr_root) begin
                r_root_zero <= i_wr_zero;
            end
            if (i_ctl.wr_one && wr_root) begin
                r_root_one <= i_wr_one;
            end
            if (i_ctl.wr_mark && wr_root) begin
                r_root_has <= i_wr_has;
            end
            if (i_ctl.rd_en) begin
                r_rd_root <= (i_rd_addr == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_mark && wr_root) begin
            r_root_id <= i_wr_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_zero && !wr_root) begin
            mem_zero[i_wr_addr] <= i_wr_zero;
        end
        if (i_ctl.wr_one && !wr_root) begin
            mem_one[i_wr_addr] <= i_wr_one;
        end
        if (i_ctl.wr_mark && !wr_root) begin
            mem_has[i_wr_addr] <= i_wr_has;
            mem_id[i_wr_addr]  <= i_wr_id;
        end
        if (i_ctl.rd_en) begin
            r_q_zero <= mem_zero[i_rd_addr];
            r_q_one  <= mem_one[i_rd_addr];
            r_q_has  <= mem_has[i_rd_addr];
            r_q_id   <= mem_id[i_rd_addr];
        end
    end

    assign o_q_zero = r_rd_root ? r_root_zero : r_q_zero;
    assign o_q_one  = r_rd_root ? r_root_one  : r_q_one;
    assign o_q_has  = r_rd_root ? r_root_has  : r_q_has;
    assign o_q_id   = r_rd_root ? r_root_id   : r_q_id;

endmodule

// File: sv/btpl_seq.sv
// ----------------------------------------------------------------------------
// btpl_seq
// Trie walk sequencer: one node per cycle for lookup and insert, node
// allocation from the free pointer, and the result register.
// ----------------------------------------------------------------------------
module btpl_seq #(
    parameter int NODE_COUNT = btpl_pkg::NODE_COUNT_DEF,
    parameter int ID_BITS    = btpl_pkg::ID_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic                                i_cmd,
    input  logic [btpl_pkg::ADDR_BITS-1:0]      i_addr,
    input  logic [btpl_pkg::LEN_W-1:0]          i_len,
    input  logic [btpl_pkg::OUT_ID_W-1:0]       i_id,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic                                o_status,
    output logic                                o_hit,
    output logic [btpl_pkg::OUT_ID_W-1:0]       o_mid,
    output btpl_pkg::t_mem_ctl                  o_ctl,
    output logic [$clog2(NODE_COUNT)-1:0]       o_rd_addr,
    output logic [$clog2(NODE_COUNT)-1:0]       o_wr_addr,
    output logic [$clog2(NODE_COUNT)-1:0]       o_wr_zero,
    output logic [$clog2(NODE_COUNT)-1:0]       o_wr_one,
    output logic                                o_wr_has,
    output logic [ID_BITS-1:0]                  o_wr_id,
    input  logic [$clog2(NODE_COUNT)-1:0]       i_q_zero,
    input  logic [$clog2(NODE_COUNT)-1:0]       i_q_one,
    input  logic                                i_q_has,
    input  logic [ID_BITS-1:0]                  i_q_id
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int FREE_W = $clog2(NODE_COUNT + 1);
    localparam int AW     = btpl_pkg::ADDR_BITS;
    localparam int LW     = btpl_pkg::LEN_W;
    localparam int OW     = btpl_pkg::OUT_ID_W;
    localparam logic [FREE_W-1:0] POOL_END = FREE_W'(NODE_COUNT);
    localparam logic [LW-1:0]     MAX_LEN  = LW'(btpl_pkg::ADDR_BITS);

    btpl_pkg::t_state r_state, n_state;
    logic              r_cmd, n_cmd;
    logic [AW-1:0]     r_addr, n_addr;
    logic [LW-1:0]     r_cnt, n_cnt;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [FREE_W-1:0] r_free, n_free;
    logic              r_hit, n_hit;
    logic [ID_BITS-1:0] r_mid, n_mid;
    logic              r_ov, n_ov;
    logic              r_o_status, n_o_status;
    logic              r_o_hit, n_o_hit;
    logic [OW-1:0]     r_o_mid, n_o_mid;

    logic              bit_v;
    logic [IDX_W-1:0]  nxt;
    logic              out_free;
    logic              pool_full;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  child;
    logic              acc_hit;
    logic [ID_BITS-1:0] acc_mid;

    assign bit_v     = r_addr[AW-1];
    assign nxt       = bit_v ? i_q_one : i_q_zero;
    assign out_free  = !r_ov || i_m_tready;
    assign pool_full = (r_free == POOL_END);
    assign free_idx  = r_free[IDX_W-1:0];
    assign child     = pool_full ? '0 : free_idx;
    assign acc_hit   = r_hit | i_q_has;
    assign acc_mid   = i_q_has ? i_q_id : r_mid;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_cnt      = r_cnt;
        n_id       = r_id;
        n_cur      = r_cur;
        n_free     = r_free;
        n_hit      = r_hit;
        n_mid      = r_mid;
        n_ov       = r_ov && !i_m_tready;
        n_o_status = r_o_status;
        n_o_hit    = r_o_hit;
        n_o_mid    = r_o_mid;
        o_ctl      = '0;
        o_rd_addr  = nxt;
        o_wr_addr  = r_cur;
        o_wr_zero  = free_idx;
        o_wr_one   = free_idx;
        o_wr_has   = 1'b1;
        o_wr_id    = r_id;

        unique case (r_state)
            btpl_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd       = i_cmd;
                    n_addr      = i_addr;
                    n_cnt       = (i_cmd == btpl_pkg::CMD_INSERT) ?
                                  ((i_len > MAX_LEN) ? MAX_LEN : i_len) : MAX_LEN;
                    n_id        = ID_BITS'(i_id);
                    n_cur       = '0;
                    n_hit       = 1'b0;
                    n_mid       = '0;
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = '0;
                    n_state     = btpl_pkg::S_WALK;
                end
            end
            btpl_pkg::S_WALK: begin
                if (r_cmd == btpl_pkg::CMD_LOOKUP) begin
                    if (r_cnt == '0 || nxt == '0) begin
                        if (out_free) begin
                            n_ov       = 1'b1;
                            n_o_status = btpl_pkg::STATUS_DONE;
                            n_o_hit    = acc_hit;
                            n_o_mid    = OW'(acc_mid);
                            n_state    = btpl_pkg::S_IDLE;
                        end
                    end else begin
                        n_hit       = acc_hit;
                        n_mid       = acc_mid;
                        o_ctl.rd_en = 1'b1;
                        n_cur       = nxt;
                        n_addr      = r_addr << 1;
                        n_cnt       = r_cnt - 1'b1;
                    end
                end else begin
                    if (r_cnt == '0) begin
                        if (out_free) begin
                            o_ctl.wr_mark = 1'b1;
                            n_ov          = 1'b1;
                            n_o_status    = btpl_pkg::STATUS_DONE;
                            n_o_hit       = 1'b0;
                            n_o_mid       = '0;
                            n_state       = btpl_pkg::S_IDLE;
                        end
                    end else if (nxt != '0) begin
                        o_ctl.rd_en = 1'b1;
                        n_cur       = nxt;
                        n_addr      = r_addr << 1;
                        n_cnt       = r_cnt - 1'b1;
                    end else if (pool_full) begin
                        if (out_free) begin
                            n_ov       = 1'b1;
                            n_o_status = btpl_pkg::STATUS_FULL;
                            n_o_hit    = 1'b0;
                            n_o_mid    = '0;
                            n_state    = btpl_pkg::S_IDLE;
                        end
                    end else begin
                        // link the first new node under the existing parent
                        o_ctl.wr_zero = !bit_v;
                        o_ctl.wr_one  = bit_v;
                        n_cur         = free_idx;
                        n_free        = r_free + 1'b1;
                        n_addr        = r_addr << 1;
                        n_cnt         = r_cnt - 1'b1;
                        n_state       = btpl_pkg::S_ALLOC;
                    end
                end
            end
            btpl_pkg::S_ALLOC: begin
                // write the fresh node whole, pointing at the next one if any
                o_ctl.wr_zero = 1'b1;
                o_ctl.wr_one  = 1'b1;
                o_ctl.wr_mark = 1'b1;
                if (r_cnt == '0) begin
                    o_wr_zero = '0;
                    o_wr_one  = '0;
                    o_wr_has  = 1'b1;
                    if (out_free) begin
                        n_ov       = 1'b1;
                        n_o_status = btpl_pkg::STATUS_DONE;
                        n_o_hit    = 1'b0;
                        n_o_mid    = '0;
                        n_state    = btpl_pkg::S_IDLE;
                    end
                end else begin
                    o_wr_zero = bit_v ? '0 : child;
                    o_wr_one  = bit_v ? child : '0;
                    o_wr_has  = 1'b0;
                    if (!pool_full) begin
                        n_cur  = free_idx;
                        n_free = r_free + 1'b1;
                        n_addr = r_addr << 1;
                        n_cnt  = r_cnt - 1'b1;
                    end else if (out_free) begin
                        n_ov       = 1'b1;
                        n_o_status = btpl_pkg::STATUS_FULL;
                        n_o_hit    = 1'b0;
                        n_o_mid    = '0;
                        n_state    = btpl_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = btpl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btpl_pkg::S_IDLE;
            r_free  <= FREE_W'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_cnt      <= n_cnt;
        r_id       <= n_id;
        r_cur      <= n_cur;
        r_hit      <= n_hit;
        r_mid      <= n_mid;
        r_o_status <= n_o_status;
        r_o_hit    <= n_o_hit;
        r_o_mid    <= n_o_mid;
    end

    assign o_s_tready = (r_state == btpl_pkg::S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_status   = r_o_status;
    assign o_hit      = r_o_hit;
    assign o_mid      = r_o_mid;

endmodule

// File: sv/binary_trie_prefix_lookup_core.sv
// ----------------------------------------------------------------------------
// binary_trie_prefix_lookup_core
// One node memory read or write per cycle during the walk, for lookup and
// insert alike; one transaction at a time, and s_axis_tready rises in the
// same cycle as m_axis_tvalid for the result.
// Reset: synchronous; clears root node links and mark, free pointer and
// handshake state, with no clearing pass over the node memory.
// Binary trie longest prefix match for IPv4 over a fixed node pool.
// ----------------------------------------------------------------------------
module binary_trie_prefix_lookup_core #(
    parameter int NODE_COUNT = btpl_pkg::NODE_COUNT_DEF,
    parameter int ID_BITS    = btpl_pkg::ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // address[31:0], prefix_length[37:32],
                                        // prefix_id[53:38], zero pad
    input  logic [0:0]  s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // match_id[15:0]
    output logic [1:0]  m_axis_tuser    // status[0], hit[1]
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    btpl_pkg::t_mem_ctl mem_ctl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   wr_zero;
    logic [IDX_W-1:0]   wr_one;
    logic               wr_has;
    logic [ID_BITS-1:0] wr_id;
    logic [IDX_W-1:0]   q_zero;
    logic [IDX_W-1:0]   q_one;
    logic               q_has;
    logic [ID_BITS-1:0] q_id;
    logic               status;
    logic               hit;

    btpl_seq #(
        .NODE_COUNT (NODE_COUNT),
        .ID_BITS    (ID_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_cmd      (s_axis_tuser[0]),
        .i_addr     (s_axis_tdata[31:0]),
        .i_len      (s_axis_tdata[37:32]),
        .i_id       (s_axis_tdata[53:38]),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_status   (status),
        .o_hit      (hit),
        .o_mid      (m_axis_tdata),
        .o_ctl      (mem_ctl),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_wr_zero  (wr_zero),
        .o_wr_one   (wr_one),
        .o_wr_has   (wr_has),
        .o_wr_id    (wr_id),
        .i_q_zero   (q_zero),
        .i_q_one    (q_one),
        .i_q_has    (q_has),
        .i_q_id     (q_id)
    );

    btpl_node_mem #(
        .NODE_COUNT (NODE_COUNT),
        .ID_BITS    (ID_BITS)
    ) u_node_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_zero (wr_zero),
        .i_wr_one  (wr_one),
        .i_wr_has  (wr_has),
        .i_wr_id   (wr_id),
        .o_q_zero  (q_zero),
        .o_q_one   (q_one),
        .o_q_has   (q_has),
        .o_q_id    (q_id)
    );

    assign m_axis_tuser = {hit, status};

endmodule
